// ===== rtl/rgb_led_strip_frame_serializer_unit_macros.svh =====
// Assertion macros shared by the checker of the LED strip frame serializer.
// No dependencies; pulled in by the checker file through `include.
`ifndef RGB_LED_STRIP_FRAME_SERIALIZER_UNIT_MACROS_SVH
`define RGB_LED_STRIP_FRAME_SERIALIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLSFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error("rlsfs implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RLSFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error("rlsfs next-cycle check failed");

`endif

// ===== rtl/rlsfs_pkg.sv =====
// Shared types and constants of the LED strip frame serializer.
// No dependencies; used by the controller, the datapath and the top level.
package rlsfs_pkg;

    localparam int COUNT_W    = 7;
    localparam int INDEX_W    = 6;
    localparam int COLOR_W    = 8;
    localparam int PIXEL_BITS = 3 * COLOR_W;

    localparam logic [1:0] SLOT_FIRST = 2'd0;
    localparam logic [1:0] SLOT_LAST  = 2'd3;
    localparam logic [4:0] BIT_LAST   = 5'(PIXEL_BITS - 1);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FILL  = 2'd2,
        ACT_START = 2'd3
    } t_action;

    typedef struct packed {
        logic wr_pixel;
        logic fill_start;
        logic fill_step;
        logic frame_start;
        logic tick_reset;
        logic tick_pixel;
        logic read_next;
    } t_cmd;

    typedef struct packed {
        logic idx_ok;
        logic n_zero;
        logic rst_last;
        logic pos_out;
        logic pixel_end;
        logic pos_next_last;
        logic fill_last;
        logic level;
    } t_status;

endpackage

// ===== rtl/rlsfs_datapath.sv =====
// Datapath of the LED strip frame serializer: pixel memory, slot counters,
// bit shifter and the LED count register. Depends on rlsfs_pkg.
module rlsfs_datapath #(
    parameter int MAX_LEDS    = 64,
    parameter int RESET_SLOTS = 200
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rlsfs_pkg::COUNT_W-1:0]     i_cfg_data,
    input  logic [rlsfs_pkg::INDEX_W-1:0]     i_pixel_index,
    input  logic [rlsfs_pkg::COLOR_W-1:0]     i_red,
    input  logic [rlsfs_pkg::COLOR_W-1:0]     i_green,
    input  logic [rlsfs_pkg::COLOR_W-1:0]     i_blue,
    input  rlsfs_pkg::t_cmd                   i_cmd,
    output rlsfs_pkg::t_status                o_status
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CW = $clog2(MAX_LEDS + 1);
    localparam int NW = (CW > rlsfs_pkg::COUNT_W) ? CW : rlsfs_pkg::COUNT_W;
    localparam int RW = $clog2(RESET_SLOTS + 1);
    localparam int PW = rlsfs_pkg::PIXEL_BITS;
    localparam logic [NW-1:0] MAX_N   = NW'(MAX_LEDS);
    localparam logic [CW-1:0] MAX_C   = CW'(MAX_LEDS);
    localparam logic [RW-1:0] RS_LAST = RW'(RESET_SLOTS - 1);

    logic [rlsfs_pkg::COUNT_W-1:0] r_led_count;
    logic [RW-1:0]                 r_rst_cnt;
    logic [CW-1:0]                 r_pix_pos;
    logic [4:0]                    r_bit_pos;
    logic [1:0]                    r_slot;
    logic [PW-1:0]                 r_shift;
    logic [CW-1:0]                 r_fill_addr;
    logic [PW-1:0]                 r_fill_color;
    logic [NW-1:0]                 r_fill_n;
    logic [PW-1:0]                 r_mem [MAX_LEDS];
    logic [MAX_LEDS-1:0]           r_valid;
    logic [PW-1:0]                 r_rd;

    logic [NW-1:0] count_ext;
    logic [NW-1:0] active_n;
    logic [NW-1:0] pos_ext;
    logic [NW-1:0] fill_ext;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [PW-1:0] wr_data;
    logic [CW-1:0] rd_ptr;
    logic [AW-1:0] rd_addr;
    logic          rd_ok;

    assign count_ext = NW'(r_led_count);
    assign active_n  = (count_ext > MAX_N) ? MAX_N : count_ext;
    assign pos_ext   = NW'(r_pix_pos);
    assign fill_ext  = NW'(r_fill_addr);

    always_comb begin
        o_status.idx_ok        = NW'(i_pixel_index) < active_n;
        o_status.n_zero        = active_n == '0;
        o_status.rst_last      = r_rst_cnt == RS_LAST;
        o_status.pos_out       = pos_ext >= active_n;
        o_status.pixel_end     = (r_slot == rlsfs_pkg::SLOT_LAST)
                                 && (r_bit_pos == rlsfs_pkg::BIT_LAST);
        o_status.pos_next_last = NW'(pos_ext + 1'b1) >= active_n;
        o_status.fill_last     = NW'(fill_ext + 1'b1) >= r_fill_n;
        unique case (r_slot)
            rlsfs_pkg::SLOT_FIRST: o_status.level = 1'b1;
            rlsfs_pkg::SLOT_LAST:  o_status.level = 1'b0;
            default:               o_status.level = r_shift[PW-1];
        endcase
    end

    // One write port shared by single writes and the fill sweep.
    assign wr_en   = i_cmd.wr_pixel || i_cmd.fill_step;
    assign wr_addr = i_cmd.fill_step ? AW'(r_fill_addr) : AW'(i_pixel_index);
    assign wr_data = i_cmd.fill_step ? r_fill_color : {i_green, i_red, i_blue};

    // The read port prefetches the pixel after the current one, or pixel 0
    // until the pixel phase of a frame begins.
    assign rd_ptr  = i_cmd.read_next ? CW'(r_pix_pos + 1'b1) : '0;
    assign rd_addr = AW'(rd_ptr);
    assign rd_ok   = rd_ptr < MAX_C;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= (rd_ok && r_valid[rd_addr]) ? r_mem[rd_addr] : '0;
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= '0;
            r_rst_cnt   <= '0;
            r_pix_pos   <= '0;
            r_bit_pos   <= '0;
            r_slot      <= '0;
            r_fill_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_led_count <= i_cfg_data;
            end
            if (i_cmd.fill_start) begin
                r_fill_addr <= '0;
            end else if (i_cmd.fill_step) begin
                r_fill_addr <= CW'(r_fill_addr + 1'b1);
            end
            if (i_cmd.frame_start) begin
                r_rst_cnt <= '0;
                r_pix_pos <= '0;
                r_bit_pos <= '0;
                r_slot    <= '0;
            end else if (i_cmd.tick_reset) begin
                r_rst_cnt <= RW'(r_rst_cnt + 1'b1);
            end else if (i_cmd.tick_pixel) begin
                r_slot <= 2'(r_slot + 1'b1);
                if (r_slot == rlsfs_pkg::SLOT_LAST) begin
                    if (r_bit_pos == rlsfs_pkg::BIT_LAST) begin
                        r_bit_pos <= '0;
                        r_pix_pos <= CW'(r_pix_pos + 1'b1);
                    end else begin
                        r_bit_pos <= 5'(r_bit_pos + 1'b1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // The sweep length is fixed when the fill is taken, so a later count
        // write does not change which pixels the fill covers.
        if (i_cmd.fill_start) begin
            r_fill_color <= {i_green, i_red, i_blue};
            r_fill_n     <= active_n;
        end
        if (i_cmd.tick_reset && o_status.rst_last) begin
            r_shift <= r_rd;
        end else if (i_cmd.tick_pixel && (r_slot == rlsfs_pkg::SLOT_LAST)) begin
            if (r_bit_pos == rlsfs_pkg::BIT_LAST) begin
                r_shift <= r_rd;
            end else begin
                r_shift <= {r_shift[PW-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== rtl/rlsfs_ctrl.sv =====
// Controller of the LED strip frame serializer: handshakes, frame and fill
// sequencing, and the result register. Depends on rlsfs_pkg.
module rlsfs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_line_level,
    output logic               o_busy_res,
    output logic               o_accepted,
    output logic               o_frame_last,
    output rlsfs_pkg::t_cmd    o_cmd,
    input  rlsfs_pkg::t_status i_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_RESET,
        S_PIXEL
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   r_pin, n_pin;
    logic   r_busy, n_busy;
    logic   r_acc, n_acc;
    logic   r_last, n_last;

    rlsfs_pkg::t_action act;
    logic               sending;
    logic               accept;

    assign act     = rlsfs_pkg::t_action'(i_action);
    assign sending = (r_state == S_RESET) || (r_state == S_PIXEL);
    assign o_ready = (r_state != S_FILL) && (!r_valid || i_ready);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_pin   = r_pin;
        n_busy  = r_busy;
        n_acc   = r_acc;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.read_next = r_state == S_PIXEL;

        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end

        // The fill sweep writes one pixel a cycle while input is held off.
        if (r_state == S_FILL) begin
            o_cmd.fill_step = 1'b1;
            if (i_status.fill_last) begin
                n_state = S_IDLE;
            end
        end

        if (accept) begin
            n_valid = 1'b1;
            n_pin   = 1'b0;
            n_busy  = sending;
            n_acc   = 1'b0;
            n_last  = 1'b0;
            unique case (act)
                rlsfs_pkg::ACT_TICK: begin
                    n_acc = 1'b1;
                    if (r_state == S_RESET) begin
                        o_cmd.tick_reset = 1'b1;
                        if (i_status.rst_last) begin
                            if (i_status.n_zero) begin
                                n_last  = 1'b1;
                                n_state = S_IDLE;
                            end else begin
                                n_state = S_PIXEL;
                            end
                        end
                    end else if (r_state == S_PIXEL) begin
                        // A count lowered below the position ends the frame
                        // with a low slot.
                        if (i_status.pos_out) begin
                            n_last  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.tick_pixel = 1'b1;
                            n_pin = i_status.level;
                            if (i_status.pixel_end && i_status.pos_next_last) begin
                                n_last  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end
                    end
                end
                rlsfs_pkg::ACT_WRITE: begin
                    if (!sending) begin
                        n_acc          = i_status.idx_ok;
                        o_cmd.wr_pixel = i_status.idx_ok;
                    end
                end
                rlsfs_pkg::ACT_FILL: begin
                    if (!sending) begin
                        n_acc            = 1'b1;
                        o_cmd.fill_start = 1'b1;
                        if (!i_status.n_zero) begin
                            n_state = S_FILL;
                        end
                    end
                end
                rlsfs_pkg::ACT_START: begin
                    if (!sending) begin
                        n_acc             = 1'b1;
                        n_busy            = 1'b1;
                        o_cmd.frame_start = 1'b1;
                        n_state           = S_RESET;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_pin   <= n_pin;
            r_busy  <= n_busy;
            r_acc   <= n_acc;
            r_last  <= n_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_line_level = r_pin;
    assign o_busy_res   = r_busy;
    assign o_accepted   = r_acc;
    assign o_frame_last = r_last;

endmodule

// ===== rtl/rgb_led_strip_frame_serializer_unit.sv =====
// Top level of the LED strip frame serializer: controller plus datapath.
// Depends on rlsfs_pkg, rlsfs_ctrl and rlsfs_datapath.
//
//   Channel   Handshake           Beat contents
//   input     i_valid / o_ready   i_action, i_pixel_index, i_red, i_green, i_blue
//   output    o_valid / i_ready   o_line_level, o_busy_res, o_accepted, o_frame_last
//   config    i_cfg_we            i_cfg_data (LED count)
//
// Every input beat gives one output beat. Ticks, writes and starts complete
// when taken, so slots can stream at one per clock while results are drained.
// A fill sweeps the active LED count of pixels (a count above MAX_LEDS sweeps
// MAX_LEDS pixels): the single write port of the pixel memory is swept one
// pixel per cycle, and input is held off during the sweep.
// Synchronous reset clears control state and the per-pixel valid flags, so the
// pixel memory reads as zero right after reset with no clearing pass.
// A result waits in an output register; a new beat is taken in the same cycle
// the previous result is drained.
module rgb_led_strip_frame_serializer_unit #(
    parameter int MAX_LEDS    = 64,
    parameter int RESET_SLOTS = 200
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rlsfs_pkg::COUNT_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_action,
    input  logic [rlsfs_pkg::INDEX_W-1:0] i_pixel_index,
    input  logic [rlsfs_pkg::COLOR_W-1:0] i_red,
    input  logic [rlsfs_pkg::COLOR_W-1:0] i_green,
    input  logic [rlsfs_pkg::COLOR_W-1:0] i_blue,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_line_level,
    output logic                          o_busy_res,
    output logic                          o_accepted,
    output logic                          o_frame_last
);

    rlsfs_pkg::t_cmd    cmd;
    rlsfs_pkg::t_status status;

    rlsfs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_line_level (o_line_level),
        .o_busy_res   (o_busy_res),
        .o_accepted   (o_accepted),
        .o_frame_last (o_frame_last),
        .o_cmd        (cmd),
        .i_status     (status)
    );

    rlsfs_datapath #(
        .MAX_LEDS    (MAX_LEDS),
        .RESET_SLOTS (RESET_SLOTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_pixel_index (i_pixel_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_cmd         (cmd),
        .o_status      (status)
    );

endmodule

// ===== rtl/rlsfs_checker.sv =====
// Port-level checker for the LED strip frame serializer, bound to the top.
// Depends on rgb_led_strip_frame_serializer_unit_macros.svh.
`include "rgb_led_strip_frame_serializer_unit_macros.svh"

module rlsfs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input logic o_line_level,
    input logic o_busy_res,
    input logic o_accepted,
    input logic o_frame_last
);

    // A high slot only comes from a tick of a running frame.
    `RLSFS_ASSERT_IMPLY(a_pin_needs_busy, i_clk, i_rst_n, o_valid && o_line_level, o_busy_res && o_accepted)

    // The final slot of a frame is still reported busy and is never high.
    `RLSFS_ASSERT_IMPLY(a_last_is_low_busy, i_clk, i_rst_n, o_valid && o_frame_last, o_busy_res && o_accepted && !o_line_level)

    // A refused beat produces neither a slot nor a frame end.
    `RLSFS_ASSERT_IMPLY(a_refused_quiet, i_clk, i_rst_n, o_valid && !o_accepted, !o_line_level && !o_frame_last)

    // A stalled result holds.
    `RLSFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_line_level) && $stable(o_frame_last))

endmodule

bind rgb_led_strip_frame_serializer_unit rlsfs_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_line_level (o_line_level),
    .o_busy_res   (o_busy_res),
    .o_accepted   (o_accepted),
    .o_frame_last (o_frame_last)
);
